[design/i2da_pkg.sv]
// i2da_pkg: constants and types for the int64 to decimal ascii converter
// no dependencies
`default_nettype none

package i2da_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int IN_WIDTH    = 64;
    localparam int CHAR_WIDTH  = 6;
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 31) / 100 + 1;
    localparam int BCD_WIDTH   = NUM_DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = CHAR_WIDTH'(48);
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = CHAR_WIDTH'(45);

    typedef logic [IN_WIDTH-1:0]   value_t;
    typedef logic [CHAR_WIDTH-1:0] char_t;

endpackage

`default_nettype wire

[design/i2da_in_if.sv]
// i2da_in_if: valid/ready channel carrying one signed integer word
// depends on i2da_pkg
`default_nettype none

interface i2da_in_if;
    logic             valid;
    logic             ready;
    i2da_pkg::value_t value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

[design/i2da_out_if.sv]
// i2da_out_if: valid/ready channel carrying one ascii character word
// depends on i2da_pkg
`default_nettype none

interface i2da_out_if;
    logic            valid;
    logic            ready;
    i2da_pkg::char_t out_char;
    logic            last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

[design/int64_to_decimal_ascii.sv]
// int64_to_decimal_ascii: signed integer to decimal ascii text, serial double dabble
// depends on i2da_pkg, i2da_in_if, i2da_out_if
//
// Usage:
//   din carries one signed integer word; dout returns its decimal text, one
//   ascii character word at a time, most significant first, with last set on
//   the final character. Negative values start with '-'; zero gives '0'.
//   din.ready is high only while the converter is idle; one number is in
//   flight at a time.
//   Steps per number: accept while idle, shift-and-add-3 for each input bit
//   in the single BCD adjust block, which corrects every digit at once, then
//   a pass over the BCD digits, each either dropped as a leading zero or emitted,
//   plus one sign step that emits '-' for a negative value. With no stall the
//   time from one accept to the next is the same whatever the number's
//   length; the bit-serial conversion loop takes most of it.
//   Results leave through a one-word output register, so the final character
//   may wait there while the next number is accepted. When dout stalls the
//   emitter holds its digit and waits; nothing is dropped.
//   Reset (rst_n low, asynchronous) returns to idle and empties the output.
`default_nettype none

module int64_to_decimal_ascii (
    input  wire          clk,
    input  wire          rst_n,
    i2da_in_if.sink      din,
    i2da_out_if.source   dout
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                             state_reg, state_next;
    logic [i2da_pkg::VALUE_WIDTH-1:0]   bin_reg, bin_next;
    logic [i2da_pkg::BCD_WIDTH-1:0]     bcd_reg, bcd_next;
    logic [i2da_pkg::BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [i2da_pkg::DIG_CNT_W-1:0]     dig_left_reg, dig_left_next;
    logic                               neg_reg, neg_next;
    logic                               ov_reg, ov_next;
    i2da_pkg::char_t                    och_reg, och_next;
    logic                               olast_reg, olast_next;

    logic [i2da_pkg::VALUE_WIDTH-1:0]   raw;
    logic [i2da_pkg::VALUE_WIDTH-1:0]   mag;
    logic [i2da_pkg::BCD_WIDTH-1:0]     bcd_adj;
    logic [3:0]                         top_digit;
    logic                               load_ok;

    assign raw       = din.value[i2da_pkg::VALUE_WIDTH-1:0];
    assign mag       = raw[i2da_pkg::VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
    assign top_digit = bcd_reg[i2da_pkg::BCD_WIDTH-1 -: 4];
    assign load_ok   = !ov_reg || dout.ready;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < i2da_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_left_next = dig_left_reg;
        neg_next      = neg_reg;
        ov_next       = ov_reg;
        och_next      = och_reg;
        olast_next    = olast_reg;

        if (ov_reg && dout.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    bin_next      = mag;
                    bcd_next      = '0;
                    bit_cnt_next  = '0;
                    dig_left_next = i2da_pkg::DIG_CNT_W'(i2da_pkg::NUM_DIGITS);
                    neg_next      = raw[i2da_pkg::VALUE_WIDTH-1];
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[i2da_pkg::BCD_WIDTH-2:0],
                            bin_reg[i2da_pkg::VALUE_WIDTH-1]};
                bin_next = {bin_reg[i2da_pkg::VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == i2da_pkg::BIT_CNT_W'(i2da_pkg::VALUE_WIDTH - 1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == 4'd0 && dig_left_reg > 1)
                begin
                    bcd_next      = {bcd_reg[i2da_pkg::BCD_WIDTH-5:0], 4'd0};
                    dig_left_next = dig_left_reg - 1'b1;
                end
                else if (!neg_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (load_ok)
                begin
                    ov_next    = 1'b1;
                    och_next   = i2da_pkg::CHAR_MINUS;
                    olast_next = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    ov_next       = 1'b1;
                    och_next      = i2da_pkg::CHAR_ZERO + {2'b00, top_digit};
                    olast_next    = (dig_left_reg == 1);
                    bcd_next      = {bcd_reg[i2da_pkg::BCD_WIDTH-5:0], 4'd0};
                    dig_left_next = dig_left_reg - 1'b1;
                    if (dig_left_reg == 1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bin_reg      <= '0;
            bcd_reg      <= '0;
            bit_cnt_reg  <= '0;
            dig_left_reg <= '0;
            neg_reg      <= 1'b0;
            ov_reg       <= 1'b0;
            och_reg      <= '0;
            olast_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bin_reg      <= bin_next;
            bcd_reg      <= bcd_next;
            bit_cnt_reg  <= bit_cnt_next;
            dig_left_reg <= dig_left_next;
            neg_reg      <= neg_next;
            ov_reg       <= ov_next;
            och_reg      <= och_next;
            olast_reg    <= olast_next;
        end
    end

    assign din.ready     = (state_reg == ST_IDLE);
    assign dout.valid    = ov_reg;
    assign dout.out_char = och_reg;
    assign dout.last     = olast_reg;

endmodule

`default_nettype wire

[tb/int64_to_decimal_ascii_test.sv]
// int64_to_decimal_ascii_test: checks the decimal text of signed 64-bit words against a
// predictor, with bursty input, a stalling receiver and a quiet-cycle watchdog
// depends on i2da_pkg, i2da_in_if, i2da_out_if and int64_to_decimal_ascii
`default_nettype none

module int64_to_decimal_ascii_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        i2da_pkg::char_t ch;
        logic            last;
    } text_char_t;

    typedef enum {RX_STREAM, RX_JITTER, RX_STALLS} rx_mode_t;
    typedef enum {KIND_FULL, KIND_SHORT, KIND_DECADE} value_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    i2da_in_if  num_ch ();
    i2da_out_if text_ch ();

    int64_to_decimal_ascii i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (num_ch),
        .dout  (text_ch)
    );

    text_char_t  expected_chars[$];
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic i2da_pkg::value_t power_of_ten(input int k);
        i2da_pkg::value_t p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    function automatic void predict_text(input i2da_pkg::value_t word);
        logic [i2da_pkg::VALUE_WIDTH-1:0] raw;
        logic [i2da_pkg::VALUE_WIDTH-1:0] mag;
        logic                             neg;
        i2da_pkg::char_t                  digits[$];
        raw = word[i2da_pkg::VALUE_WIDTH-1:0];
        neg = raw[i2da_pkg::VALUE_WIDTH-1];
        mag = neg ? -raw : raw;
        do
        begin
            digits.push_front(i2da_pkg::CHAR_ZERO + i2da_pkg::char_t'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        if (neg)
            digits.push_front(i2da_pkg::CHAR_MINUS);
        foreach (digits[i])
            expected_chars.push_back(text_char_t'{digits[i], i == digits.size() - 1});
    endfunction

    function automatic void note_mismatch(input string what, input text_char_t want,
                                          input i2da_pkg::char_t got_ch,
                                          input logic got_last);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%0t: %s: expected char %0d last %0b, got char %0d last %0b",
                     $realtime, what, want.ch, want.last, got_ch, got_last);
    endfunction

    // sender: bursts of words with idle gaps between them
    task automatic send_value(input i2da_pkg::value_t word);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
        end
        num_ch.valid <= 1'b1;
        num_ch.value <= word;
        @(posedge clk);
        while (!num_ch.ready)
            @(posedge clk);
        predict_text(word);
        burst_left--;
        if (burst_left == 0)
            num_ch.valid <= 1'b0;
    endtask

    task automatic stop_sending();
        if (burst_left != 0)
        begin
            num_ch.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic test_special_values();
        i2da_pkg::value_t words[$];
        words = '{
            i2da_pkg::value_t'(0), i2da_pkg::value_t'(1), i2da_pkg::value_t'(-64'sd1),
            i2da_pkg::value_t'(9), i2da_pkg::value_t'(-64'sd9),
            i2da_pkg::value_t'(10), i2da_pkg::value_t'(-64'sd10),
            i2da_pkg::value_t'(99), i2da_pkg::value_t'(100),
            64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE,
            64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
            power_of_ten(18), power_of_ten(18) - 1, -power_of_ten(18),
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000
        };
        foreach (words[i])
            send_value(words[i]);
    endtask

    task automatic test_random_values();
        i2da_pkg::value_t word;
        value_kind_t      kind;
        int               len;
        repeat (RANDOM_ITEMS)
        begin
            kind = value_kind_t'($urandom_range(0, 2));
            case (kind)
                KIND_FULL:
                    word = {$urandom, $urandom};
                KIND_SHORT:
                begin
                    len  = $urandom_range(1, 63);
                    word = {$urandom, $urandom} >> (64 - len);
                end
                default:
                    word = power_of_ten($urandom_range(0, 18))
                           + i2da_pkg::value_t'($urandom_range(0, 4)) - 2;
            endcase
            if (kind != KIND_FULL && $urandom_range(0, 1))
                word = -word;
            send_value(word);
        end
    endtask

    // receiver: ready pattern switches between streaming, jitter and long stalls
    initial
    begin : text_receiver
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned hold;
        mode = RX_STREAM;
        mode_left = 0;
        hold = 0;
        text_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                RX_STREAM:
                    text_ch.ready <= 1'b1;
                RX_JITTER:
                    text_ch.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (hold == 0)
                    begin
                        hold = text_ch.ready ? $urandom_range(1, 30) : $urandom_range(1, 4);
                        text_ch.ready <= !text_ch.ready;
                    end
                    else
                        hold--;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : check_text
        text_char_t want;
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            if (expected_chars.size() == 0)
                note_mismatch("unexpected word", '0, text_ch.out_char, text_ch.last);
            else
            begin
                want = expected_chars.pop_front();
                if (text_ch.out_char !== want.ch || text_ch.last !== want.last)
                    note_mismatch("wrong word", want, text_ch.out_char, text_ch.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("** int64_to_decimal_ascii: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        num_ch.valid <= 1'b0;
        num_ch.value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_values();
        test_random_values();
        stop_sending();

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_chars.size() == 0)
            $display("** int64_to_decimal_ascii: PASSED **");
        else
            $display("** int64_to_decimal_ascii: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/i2da_pkg.sv
design/i2da_in_if.sv
design/i2da_out_if.sv
design/int64_to_decimal_ascii.sv
tb/int64_to_decimal_ascii_test.sv
